[src/fit_policy_block_allocator_core_assert.svh]
// assertion macros for the fit-policy block allocator checker
// depends on: nothing, expects a clk and an arst_n in the including scope
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// clocked assertion, off while reset is applied
`define FPBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define FPBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fpba_pkg.sv]
// shared types, constants and codes of the fit-policy block allocator
// depends on: nothing
`default_nettype none

package fpba_pkg;

	localparam int NUM_BLOCKS = 8;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int LIM_W      = $clog2(NUM_BLOCKS + 1);

	// port field widths
	localparam int CMD_W  = 1;
	localparam int SEL_W  = 3;
	localparam int AMT_W  = 16;
	localparam int BLK_W  = 3;
	localparam int LEFT_W = 16;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 4;
	localparam int POL_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCKS = 1'd1;

	localparam logic [POL_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [POL_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [POL_W-1:0] FIT_WORST = 2'd2;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(NUM_BLOCKS);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} fsm_state_t;

	// search token passed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic [POL_W-1:0]     policy;
		logic [LIM_W-1:0]     limit;
		logic [SIZE_BITS-1:0] request;
		logic                 found;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] size;
	} scan_t;

	// write or charge broadcast to all cells
	typedef struct packed {
		logic                 en;
		logic                 charge;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] value;
	} upd_t;

endpackage

`default_nettype wire

[src/fit_policy_block_allocator_core.sv]
// top level of the fit-policy block allocator: control, config and the cell row
// depends on: fpba_pkg, fpba_cell
//
// channel   | handshake         | payload
// ----------+-------------------+-------------------------------------
// command   | start / busy      | command, block_select, amount
// result    | done (strobe)     | granted, chosen_block, left_over
// config    | cfg_we            | cfg_index, cfg_wdata
//
// a load is registered into the selected cell's free size and gives no result; busy stays low
// an allocate walks the search token through the cell row one cell per cycle,
//   and the chosen block is charged as the token leaves the row
// done is high for one cycle with the result; busy is already low then
// reset clears all free sizes, policy to first fit, active blocks to all
// the receiver cannot stall, so nothing ever waits on the result side
`default_nettype none

module fit_policy_block_allocator_core import fpba_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command channel
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [CMD_W-1:0]     command,
	input  wire logic [SEL_W-1:0]     block_select,
	input  wire logic [AMT_W-1:0]     amount,
	// result channel
	output logic                      done,
	output logic                      granted,
	output logic [BLK_W-1:0]          chosen_block,
	output logic [LEFT_W-1:0]         left_over,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	// configuration registers
	logic [POL_W-1:0] policy_q;
	logic [CFG_W-1:0] active_q;
	logic [LIM_W-1:0] limit;

	// control
	fsm_state_t state_q;
	fsm_state_t state_d;
	logic       accept;

	// cell row links: link[0] is the launch, link[i+1] leaves cell i
	scan_t link [NUM_BLOCKS+1];
	scan_t tail;
	upd_t  upd;

	// result registers
	logic                 done_q;
	logic                 granted_q;
	logic [IDX_W-1:0]     chosen_q;
	logic [SIZE_BITS-1:0] left_q;

	assign accept = start && !busy;

	// active blocks above the row length count as the whole row
	assign limit = (active_q > CFG_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : LIM_W'(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= FIT_FIRST;
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIT_POLICY:    policy_q <= cfg_wdata[POL_W-1:0];
				REG_ACTIVE_BLOCKS: active_q <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	// launch a fresh search token into the first cell on an allocate transfer
	always_comb begin
		link[0].valid   = accept && (command == CMD_ALLOC);
		link[0].policy  = policy_q;
		link[0].limit   = limit;
		link[0].request = SIZE_BITS'(amount);
		link[0].found   = 1'b0;
		link[0].idx     = '0;
		link[0].size    = '0;
	end

	assign tail = link[NUM_BLOCKS];

	// charge the winner when the token leaves the row, else pass a load through
	always_comb begin
		if (tail.valid) begin
			upd.en     = tail.found;
			upd.charge = 1'b1;
			upd.idx    = tail.idx;
			upd.value  = tail.request;
		end else begin
			upd.en     = accept && (command == CMD_LOAD)
				&& ({1'b0, block_select} < (SEL_W + 1)'(NUM_BLOCKS));
			upd.charge = 1'b0;
			upd.idx    = IDX_W'(block_select);
			upd.value  = SIZE_BITS'(amount);
		end
	end

	// row of identical cells, one per block
	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		fpba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (IDX_W'(i)),
			.upd      (upd),
			.scan_in  (link[i]),
			.scan_out (link[i+1])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state: busy after launch until the token leaves the last cell
	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (command == CMD_ALLOC)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				busy = 1'b1;
				if (tail.valid) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result registers: done is shown for exactly one cycle, the payload holds until the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			granted_q <= tail.found;
			chosen_q  <= tail.found ? tail.idx : '0;
			left_q    <= tail.found ? (tail.size - tail.request) : '0;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign chosen_block = BLK_W'(chosen_q);
	assign left_over    = LEFT_W'(left_q);

endmodule

`default_nettype wire

[src/fpba_cell.sv]
// one block cell: holds a free size and refines the passing search token
// depends on: fpba_pkg
`default_nettype none

module fpba_cell import fpba_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] my_idx,
	input  wire upd_t             upd,
	input  wire scan_t            scan_in,
	output scan_t                 scan_out
);

	logic [SIZE_BITS-1:0] size_q;
	scan_t                scan_q;
	scan_t                scan_d;
	logic                 fits;
	logic                 take;

	always_comb begin
		fits = scan_in.valid && (LIM_W'(my_idx) < scan_in.limit)
			&& (size_q >= scan_in.request);
		if (!scan_in.found) begin
			take = fits;
		end else begin
			case (scan_in.policy)
				FIT_BEST:  take = fits && (size_q < scan_in.size);
				FIT_WORST: take = fits && (size_q > scan_in.size);
				default:   take = 1'b0;
			endcase
		end
		scan_d = scan_in;
		if (take) begin
			scan_d.found = 1'b1;
			scan_d.idx   = my_idx;
			scan_d.size  = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
			if (upd.en && (upd.idx == my_idx)) begin
				size_q <= upd.charge ? (size_q - upd.value) : upd.value;
			end
		end
	end

	assign scan_out = scan_q;

endmodule

`default_nettype wire

[src/fpba_chk.sv]
// port-level checker for the fit-policy block allocator, bound to the top level
// depends on: fpba_pkg, fit_policy_block_allocator_core_assert.svh
`default_nettype none

`include "fit_policy_block_allocator_core_assert.svh"

module fpba_chk import fpba_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic [CMD_W-1:0]     command,
	input wire logic                 done,
	input wire logic                 granted,
	input wire logic [BLK_W-1:0]     chosen_block,
	input wire logic [LEFT_W-1:0]    left_over
);

	logic alloc_xfer;

	assign alloc_xfer = start && !busy && (command == CMD_ALLOC);

	// an allocate transfer holds the block busy until its result
	`FPBA_ASSERT(a_alloc_busy, alloc_xfer |=> busy, "allocate did not raise busy")

	// the result of an allocate appears once the token has walked the row, with the charge of the chosen block
	`FPBA_ASSERT(a_alloc_latency, alloc_xfer |-> ##(NUM_BLOCKS + 1) done, "no allocate result")

	// a result closes the search, so the block was busy just before and is free now
	`FPBA_ASSERT(a_done_frees, done |-> (!busy && $past(busy)), "result not at end of search")

	// a refused request reports zero block and zero remainder
	`FPBA_ASSERT_ALWAYS(a_refuse_zero, (done && !granted) |-> ({chosen_block, left_over} == '0), "bad refusal")

endmodule

bind fit_policy_block_allocator_core fpba_chk u_fpba_chk (.*);

`default_nettype wire
